/* sv/xcc_pkg.sv */
package xcc_pkg;

  localparam logic [7:0] LETTER_HIGH_BASE = 8'h61;  // 'a'
  localparam logic [7:0] LETTER_LOW_BASE  = 8'h6A;  // 'j'
  localparam int unsigned NIBBLE_W = 4;             // 16 letters per nibble

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAIN_KEY = 1'b1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_FORMAT   = 2'd2
  } status_t;

  // result queue geometry
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [7:0] chain_byte;
    logic [7:0] running_sum;
    logic       have_high;
    logic [7:0] high_letter;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       msg_open;
  } msg_state_t;

  localparam msg_state_t MSG_CLEAR = '{
    chain_byte:  8'd0,
    running_sum: 8'd0,
    have_high:   1'b0,
    high_letter: 8'd0,
    held_byte:   8'd0,
    held_valid:  1'b0,
    msg_open:    1'b0
  };

endpackage

/* sv/xor_chain_text_codec.sv */
// Byte stream codec with XOR chaining and a closing checksum pair.
// Input channel (in_valid / in_stall): one symbol per transfer, or an end
// item (in_is_end) that closes the message. Output channel (out_valid /
// out_stall): one result per transfer; out_is_last marks the end of a
// message and out_status carries the decode verdict on that result.
// Configuration: cfg_we with cfg_index 0 writes the direction (0 encode,
// 1 decode), index 1 writes the chain key; write only while idle.
// Each accepted item is processed combinationally and its results are
// registered in a four-entry result queue that drains one per cycle
// while out_stall is low. Encode gives two letters per item, so the
// output port sets the pace; decode takes one letter per cycle while
// in_stall is low.
// in_stall rises when the queue has fewer than two free entries.
// Reset clears the direction, the key, the message state and the queue.
// A stalled receiver holds the head result; the queue keeps taking items
// until it fills, then in_stall holds off the sender.
module xor_chain_text_codec (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_symbol,
  input  logic                                in_is_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_value,
  output logic                                out_is_last,
  output logic [1:0]                          out_status,
  input  logic                                cfg_we,
  input  logic [xcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [xcc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import xcc_pkg::*;

  logic       direction_r;
  logic [7:0] chain_key_r;
  msg_state_t state_r, state_nxt;
  result_t    res0, res1, head;
  logic [1:0] res_count;
  logic [1:0] push_count;
  logic       room;
  logic       in_take;
  logic       out_take;

  assign in_stall   = !room;
  assign in_take    = in_valid && room;
  assign out_take   = out_valid && !out_stall;
  assign push_count = in_take ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      chain_key_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION: direction_r <= cfg_wdata[0];
        REG_CHAIN_KEY: chain_key_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MSG_CLEAR;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  xcc_step u_step (
    .state     (state_r),
    .direction (direction_r),
    .chain_key (chain_key_r),
    .symbol    (in_symbol),
    .is_end    (in_is_end),
    .state_nxt (state_nxt),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  xcc_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_take)
  );

  assign out_value   = head.value;
  assign out_is_last = head.is_last;
  assign out_status  = head.status;

endmodule

/* sv/xcc_step.sv */
module xcc_step (
  input  xcc_pkg::msg_state_t state,
  input  logic                direction,
  input  logic [7:0]          chain_key,
  input  logic [7:0]          symbol,
  input  logic                is_end,
  output xcc_pkg::msg_state_t state_nxt,
  output xcc_pkg::result_t    res0,
  output xcc_pkg::result_t    res1,
  output logic [1:0]          res_count
);
  import xcc_pkg::*;

  logic [7:0] chain;
  logic [7:0] code;
  logic [7:0] pair_val;
  logic [7:0] decoded;
  status_t    end_status;

  assign chain = state.msg_open ? state.chain_byte : chain_key;

  // encode: chained byte, or the closing check byte on an end item
  assign code = is_end ? (chain ^ state.running_sum) : (chain ^ symbol);

  // decode: rebuild the byte from a letter pair, wrapping mod 256
  assign pair_val = {state.high_letter[NIBBLE_W-1:0] - LETTER_HIGH_BASE[NIBBLE_W-1:0],
                     {NIBBLE_W{1'b0}}} + symbol - LETTER_LOW_BASE;
  assign decoded  = chain ^ pair_val;

  always_comb begin
    if (!state.held_valid || state.have_high) begin
      end_status = STATUS_FORMAT;
    end else if (state.held_byte == state.running_sum) begin
      end_status = STATUS_OK;
    end else begin
      end_status = STATUS_MISMATCH;
    end
  end

  always_comb begin
    state_nxt            = state;
    state_nxt.chain_byte = chain;
    state_nxt.msg_open   = 1'b1;
    res0                 = '{value: 8'd0, is_last: 1'b0, status: STATUS_OK};
    res1                 = '{value: 8'd0, is_last: 1'b0, status: STATUS_OK};
    res_count            = 2'd0;
    if (direction == DIR_ENCODE) begin
      res0.value = LETTER_HIGH_BASE + {4'd0, code[7:4]};
      res1.value = LETTER_LOW_BASE + {4'd0, code[3:0]};
      res1.is_last = is_end;
      res_count    = 2'd2;
      if (is_end) begin
        state_nxt = MSG_CLEAR;
      end else begin
        state_nxt.chain_byte  = symbol;
        state_nxt.running_sum = state.running_sum + symbol;
      end
    end else if (is_end) begin
      res0.is_last = 1'b1;
      res0.status  = end_status;
      res_count    = 2'd1;
      state_nxt    = MSG_CLEAR;
    end else if (!state.have_high) begin
      state_nxt.high_letter = symbol;
      state_nxt.have_high   = 1'b1;
    end else begin
      state_nxt.have_high   = 1'b0;
      state_nxt.high_letter = 8'd0;
      state_nxt.held_byte   = decoded;
      state_nxt.held_valid  = 1'b1;
      state_nxt.chain_byte  = decoded;
      if (state.held_valid) begin
        // release the byte held back from the previous pair
        res0.value            = state.held_byte;
        res_count             = 2'd1;
        state_nxt.running_sum = state.running_sum + state.held_byte;
      end
    end
  end

endmodule

/* sv/xcc_result_queue.sv */
module xcc_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_count,
  input  xcc_pkg::result_t push0,
  input  xcc_pkg::result_t push1,
  output logic             room,
  output logic             head_valid,
  output xcc_pkg::result_t head,
  input  logic             pop
);
  import xcc_pkg::*;

  result_t             slot_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] count_r, count_nxt;
  logic [RQ_PTR_W-1:0] wr_ptr_p1;

  // take an item only when two slots are surely free
  assign room       = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(push_count);
    rd_ptr_nxt = rd_ptr_r + RQ_PTR_W'(pop);
    count_nxt  = count_r + RQ_CNT_W'(push_count) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slot_r[wr_ptr_r] <= push0;
    end
    if (push_count == 2'd2) begin
      slot_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

/* sv/xcc_checker.sv */
module xcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_value,
  input logic       out_is_last,
  input logic [1:0] out_status
);
  import xcc_pkg::*;

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_is_last) && $stable(out_status))
    else $error("stalled result changed");

  // a verdict comes only on the closing result
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_is_last)
    else $error("status on non-final result");

  // a verdict item carries no byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_value == 8'd0)
    else $error("status item with nonzero value");

endmodule

bind xor_chain_text_codec xcc_checker u_xcc_checker (.*);

/* bench/xcc_checker.sv */
module xcc_tb_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_is_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_value,
  input  logic       out_is_last,
  input  logic [1:0] out_status,
  input  logic       cfg_we,
  input  logic [xcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import xcc_pkg::*;

  // register copies
  logic       dir_q = DIR_ENCODE;
  logic [7:0] key_q = 8'd0;

  // message state
  logic [7:0] link_byte    = 8'd0;
  logic [7:0] byte_sum     = 8'd0;
  logic       upper_seen   = 1'b0;
  logic [7:0] upper_letter = 8'd0;
  logic [7:0] held_plain   = 8'd0;
  logic       held_ok      = 1'b0;
  logic       msg_active   = 1'b0;

  result_t codec_out_q[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    // keep the log short on a badly broken block, but count everything
    if (fail_count < 40)
      $display("mismatch at %0t: %s got %0h want %0h (result %0d)",
               $realtime, what, got, want, results_seen);
    fail_count++;
  endtask

  task automatic clear_message();
    link_byte    = 8'd0;
    byte_sum     = 8'd0;
    upper_seen   = 1'b0;
    upper_letter = 8'd0;
    held_plain   = 8'd0;
    held_ok      = 1'b0;
    msg_active   = 1'b0;
  endtask

  task automatic push_letter_pair(input logic [7:0] c, input logic last);
    result_t r;
    r.value   = LETTER_HIGH_BASE + {4'd0, c[7:4]};
    r.is_last = 1'b0;
    r.status  = STATUS_OK;
    codec_out_q.push_back(r);
    r.value   = LETTER_LOW_BASE + {4'd0, c[3:0]};
    r.is_last = last;
    codec_out_q.push_back(r);
  endtask

  task automatic codec_step(input logic [7:0] sym, input logic end_item);
    logic [7:0] packed_byte;
    logic [7:0] plain;
    status_t    verdict;
    result_t    r;
    if (!msg_active) begin
      link_byte  = key_q;
      msg_active = 1'b1;
    end
    if (dir_q == DIR_ENCODE) begin
      if (end_item) begin
        push_letter_pair(link_byte ^ byte_sum, 1'b1);
        clear_message();
      end else begin
        push_letter_pair(link_byte ^ sym, 1'b0);
        link_byte = sym;
        byte_sum  = byte_sum + sym;
      end
    end else if (end_item) begin
      if (!held_ok || upper_seen)
        verdict = STATUS_FORMAT;
      else if (held_plain == byte_sum)
        verdict = STATUS_OK;
      else
        verdict = STATUS_MISMATCH;
      r.value   = 8'd0;
      r.is_last = 1'b1;
      r.status  = verdict;
      codec_out_q.push_back(r);
      clear_message();
    end else if (!upper_seen) begin
      upper_letter = sym;
      upper_seen   = 1'b1;
    end else begin
      // letters out of range simply wrap in 8 bits
      packed_byte  = ((upper_letter - LETTER_HIGH_BASE) << NIBBLE_W) + sym - LETTER_LOW_BASE;
      plain        = link_byte ^ packed_byte;
      upper_seen   = 1'b0;
      upper_letter = 8'd0;
      if (held_ok) begin
        r.value   = held_plain;
        r.is_last = 1'b0;
        r.status  = STATUS_OK;
        codec_out_q.push_back(r);
        byte_sum = byte_sum + held_plain;
      end
      held_plain = plain;
      held_ok    = 1'b1;
      link_byte  = plain;
    end
  endtask

  task automatic check_output();
    result_t w;
    results_seen++;
    if (codec_out_q.size() == 0) begin
      report_mismatch("output with nothing awaited, value", out_value, 8'd0);
    end else begin
      w = codec_out_q.pop_front();
      if (out_value !== w.value)
        report_mismatch("out_value", out_value, w.value);
      if (out_is_last !== w.is_last)
        report_mismatch("out_is_last", {7'd0, out_is_last}, {7'd0, w.is_last});
      if (out_status !== w.status)
        report_mismatch("out_status", {6'd0, out_status}, {6'd0, w.status});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dir_q = DIR_ENCODE;
      key_q = 8'd0;
      clear_message();
      codec_out_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIRECTION)
          dir_q = cfg_wdata[0];
        else if (cfg_index == REG_CHAIN_KEY)
          key_q = cfg_wdata[7:0];
      end
      // predict first so a same-edge result still finds its entry
      if (in_valid && !in_stall)
        codec_step(in_symbol, in_is_end);
      if (out_valid && !out_stall)
        check_output();
    end
    pending = codec_out_q.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xcc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_symbol;
  logic                   in_is_end;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_value;
  logic                   out_is_last;
  logic [1:0]             out_status;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit hold_req     = 1'b0;

  logic       cur_dir = DIR_ENCODE;
  logic [7:0] cur_key = 8'd0;
  int         items_sent = 0;
  int         phase = 0;

  xor_chain_text_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_symbol  (in_symbol),
    .in_is_end  (in_is_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_is_last(out_is_last),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  xcc_tb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_symbol   (in_symbol),
    .in_is_end   (in_is_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_is_last (out_is_last),
    .out_status  (out_status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed letter stream for a plain message, checksum pair included
  function automatic byte_q_t build_letters(input logic [7:0] key, input byte_q_t plain);
    byte_q_t    letters;
    logic [7:0] link;
    logic [7:0] sum;
    logic [7:0] c;
    link = key;
    sum  = 8'd0;
    letters = {};
    for (int i = 0; i <= plain.size(); i++) begin
      c = (i == plain.size()) ? (link ^ sum) : (link ^ plain[i]);
      letters.push_back(LETTER_HIGH_BASE + {4'd0, c[7:4]});
      letters.push_back(LETTER_LOW_BASE + {4'd0, c[3:0]});
      if (i < plain.size()) begin
        link = plain[i];
        sum  = sum + plain[i];
      end
    end
    return letters;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] sym, input logic end_item);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_is_end <= end_item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input until every awaited result is out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input logic wr_dir, input logic d,
                              input logic wr_key, input logic [7:0] k);
    logic [6:0] pad;
    pad = 7'($urandom_range(0, 127));
    if (wr_dir) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_DIRECTION;
      cfg_wdata <= {pad, d};
      cur_dir = d;
      @(negedge clk);
    end
    if (wr_key) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_CHAIN_KEY;
      cfg_wdata <= k;
      cur_key = k;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_length();
    return ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(0, 6);
  endfunction

  task automatic send_encode_message();
    int n;
    n = rand_length();
    repeat (n) send_item(rand_byte(), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_decode_message();
    byte_q_t    plain;
    byte_q_t    letters;
    int         kind;
    int         n;
    int         idx;
    logic [7:0] flip;
    kind  = $urandom_range(0, 9);
    n     = rand_length();
    plain = {};
    repeat (n) plain.push_back(rand_byte());
    letters = build_letters(cur_key, plain);
    if (kind == 7) begin
      // corrupt one letter
      idx  = $urandom_range(0, letters.size() - 1);
      flip = 8'($urandom_range(1, 255));
      letters[idx] = letters[idx] ^ flip;
    end else if (kind == 8) begin
      // drop one letter to break the pairing
      idx = $urandom_range(0, letters.size() - 1);
      letters.delete(idx);
    end else if (kind == 9) begin
      letters = {};
      repeat ($urandom_range(0, 9)) letters.push_back(8'($urandom_range(0, 255)));
    end
    foreach (letters[i]) send_item(letters[i], 1'b0);
    // noise may leave the message open into the next one
    if (kind != 9 || $urandom_range(0, 1) == 1)
      send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    byte_q_t    plain;
    byte_q_t    letters;
    int         random_start;
    int         msgs;
    int         which;
    logic       d;
    logic [7:0] k;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_symbol = 8'd0;
    in_is_end = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_DIRECTION;
    cfg_wdata = 8'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // encode with the reset key, extreme bytes
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    wait_idle();
    // empty message carries only the key
    apply_config(1'b1, DIR_ENCODE, 1'b1, 8'hFF);
    send_item(8'hFF, 1'b1);
    wait_idle();

    apply_config(1'b1, DIR_DECODE, 1'b1, 8'hA5);
    plain   = '{8'h3C, 8'h00};
    letters = build_letters(cur_key, plain);
    // clean message, then the same with a broken checksum letter
    foreach (letters[i]) send_item(letters[i], 1'b0);
    send_item(8'h00, 1'b1);
    letters[letters.size() - 1] = letters[letters.size() - 1] ^ 8'h01;
    foreach (letters[i]) send_item(letters[i], 1'b0);
    send_item(8'hFF, 1'b1);
    // end with no pair at all
    send_item(8'h00, 1'b1);
    // lone letter pending at the end
    plain   = '{8'h12};
    letters = build_letters(cur_key, plain);
    send_item(letters[0], 1'b0);
    send_item(letters[1], 1'b0);
    send_item(letters[2], 1'b0);
    send_item(8'h00, 1'b1);
    // letters far outside their ranges
    send_item(8'h7A, 1'b0);
    send_item(8'h21, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    random_start = items_sent;
    while (items_sent - random_start < 1150) begin
      phase++;
      wait_idle();
      d     = (phase == 3) ? DIR_ENCODE : logic'($urandom_range(0, 1));
      k     = rand_key();
      // the long hold phase always writes the direction so it encodes
      which = (phase == 3) ? 0 : $urandom_range(0, 2);
      apply_config(which != 2, d, which != 1, k);
      if (items_sent - random_start > 1000) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
      end
      if (phase == 3) begin
        // long output hold while the sender keeps pushing
        hold_req     = 1'b1;
        send_idle_on = 1'b0;
        msgs = 10;
      end else begin
        msgs = $urandom_range(3, 8);
      end
      repeat (msgs) begin
        if (cur_dir == DIR_ENCODE)
          send_encode_message();
        else
          send_decode_message();
      end
      if (phase == 3)
        send_idle_on = 1'b1;
    end

    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d items over %0d random phases, %0d results checked",
             items_sent, phase, results_seen);
    $display("both directions, keys 00/ff/random, long output hold, bad and odd decode input");
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
